// ===== src/himm_pkg.sv =====
package himm_pkg;

	typedef enum logic [1:0] {
		REGION_ROM  = 2'd0,
		REGION_VRAM = 2'd1,
		REGION_ERAM = 2'd2,
		REGION_INT  = 2'd3
	} region_t;

	typedef enum logic [2:0] {
		MASK_NONE = 3'd0,
		MASK_FF   = 3'd1,
		MASK_C0   = 3'd2,
		MASK_40   = 3'd3,
		MASK_60   = 3'd4
	} mask_t;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	localparam logic [15:0] HRAM_BASE   = 16'hFE00;
	localparam logic [15:0] UNUSED_LO   = 16'hFEA0;
	localparam logic [15:0] UNUSED_HI   = 16'hFEFF;
	localparam logic [15:0] DIV_ADDR    = 16'hFF04;

	typedef struct packed {
		region_t    region;
		logic       wram_we;
		logic       hram_we;
		logic       hram_sel;
		logic       zero_rd;
		mask_t      mask;
		logic [7:0] wdata;
	} dec_t;

	function automatic logic [7:0] apply_mask(mask_t m, logic [7:0] b);
		logic [7:0] r;
		unique case (m)
			MASK_NONE: r = b;
			MASK_FF:   r = 8'hFF;
			MASK_C0:   r = b & 8'hC0;
			MASK_40:   r = b & 8'h40;
			MASK_60:   r = b & 8'h60;
			default:   r = b;
		endcase
		return r;
	endfunction

endpackage

// ===== src/handheld_internal_memory_map.sv =====
// Internal memory map: work RAM (mirrored echo area) and high memory.
// Request channel: bus_address, opcode and write_data are taken at a rising
// edge where start is high and busy is low. One request per cycle can be
// taken, back to back, once the block is out of reset clearing.
// Result channel: in the cycle after a request is taken, done is high for one
// cycle with read_data and region, which come from the registered read port
// of the RAMs; throughput is one request per cycle.
// A write updates the RAM at the edge that takes it, so a read in the next
// cycle already sees the new byte.
// Writes, external regions and the unused range FEA0-FEFF return read_data zero.
// After reset, busy stays high while both RAMs are swept to zero, one entry
// per cycle over all WORK_RAM_DEPTH entries (8192 by default); high memory is
// cleared within the same pass.
// The receiver cannot stall: each result is shown for its single cycle only.
module handheld_internal_memory_map import himm_pkg::*; #(
	parameter int WORK_RAM_DEPTH = 8192,
	parameter int HIGH_MEM_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] bus_address,
	input  logic        opcode,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic [1:0]  region
);

	localparam int WAW = $clog2(WORK_RAM_DEPTH);
	localparam int HAW = $clog2(HIGH_MEM_DEPTH);
	localparam logic [WAW-1:0] CLR_LAST = WAW'(WORK_RAM_DEPTH - 1);
	localparam logic [WAW-1:0] HRAM_END = WAW'(HIGH_MEM_DEPTH - 1);

	logic           clr_q;
	logic [WAW-1:0] clr_cnt_q;
	logic           accept;
	dec_t           dec;

	logic           wram_we;
	logic [WAW-1:0] wram_addr;
	logic [7:0]     wram_wdata;
	logic [7:0]     wram_rdata;
	logic           hram_we;
	logic [HAW-1:0] hram_addr;
	logic [7:0]     hram_wdata;
	logic [7:0]     hram_rdata;

	logic           valid_s1;
	region_t        region_s1;
	logic           zero_s1;
	logic           hsel_s1;
	mask_t          mask_s1;

	assign busy   = clr_q;
	assign accept = start && !clr_q;

	himm_dec u_dec (
		.bus_address (bus_address),
		.opcode      (opcode),
		.write_data  (write_data),
		.dec         (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_q) begin
			wram_we    = 1'b1;
			wram_addr  = clr_cnt_q;
			wram_wdata = 8'h00;
			hram_we    = (clr_cnt_q <= HRAM_END);
			hram_addr  = clr_cnt_q[HAW-1:0];
			hram_wdata = 8'h00;
		end else begin
			wram_we    = accept && dec.wram_we;
			wram_addr  = bus_address[WAW-1:0];
			wram_wdata = dec.wdata;
			hram_we    = accept && dec.hram_we;
			hram_addr  = bus_address[HAW-1:0];
			hram_wdata = dec.wdata;
		end
	end

	himm_ram #(.DEPTH(WORK_RAM_DEPTH)) u_wram (
		.clk   (clk),
		.we    (wram_we),
		.re    (accept),
		.addr  (wram_addr),
		.wdata (wram_wdata),
		.rdata (wram_rdata)
	);

	himm_ram #(.DEPTH(HIGH_MEM_DEPTH)) u_hram (
		.clk   (clk),
		.we    (hram_we),
		.re    (accept),
		.addr  (hram_addr),
		.wdata (hram_wdata),
		.rdata (hram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			region_s1 <= dec.region;
			zero_s1   <= dec.zero_rd;
			hsel_s1   <= dec.hram_sel;
			mask_s1   <= dec.mask;
		end
	end

	assign done      = valid_s1;
	assign region    = region_s1;
	assign read_data = zero_s1 ? 8'h00
		: apply_mask(mask_s1, hsel_s1 ? hram_rdata : wram_rdata);

	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without a request");

	a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_cnt_q == CLR_LAST))
		else $error("clearing pass ended early");

	a_clear_counts: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q && $past(clr_q) && $past(arst_n) |-> clr_cnt_q == $past(clr_cnt_q) + 1'b1)
		else $error("clearing counter skipped");

	a_data_only_internal: assert property (@(posedge clk) disable iff (!arst_n)
		done && read_data != 8'h00 |-> region == REGION_INT)
		else $error("non-zero data from external region");

endmodule

// ===== src/himm_ram.sv =====
module himm_ram import himm_pkg::*; #(
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/himm_dec.sv =====
module himm_dec import himm_pkg::*; (
	input  logic [15:0] bus_address,
	input  logic        opcode,
	input  logic [7:0]  write_data,
	output dec_t        dec
);

	logic is_int;
	logic is_hram;
	logic unusable;
	logic is_wr;

	always_comb begin
		is_wr    = (op_t'(opcode) == OP_WRITE);
		unusable = (bus_address >= UNUSED_LO) && (bus_address <= UNUSED_HI);
		is_hram  = (bus_address >= HRAM_BASE);

		priority if (!bus_address[15]) begin
			dec.region = REGION_ROM;
		end else if (bus_address[14:13] == 2'b00) begin
			dec.region = REGION_VRAM;
		end else if (bus_address[14:13] == 2'b01) begin
			dec.region = REGION_ERAM;
		end else begin
			dec.region = REGION_INT;
		end
		is_int = (dec.region == REGION_INT);

		dec.wram_we  = is_int && !is_hram && is_wr;
		dec.hram_we  = is_int && is_hram && !unusable && is_wr;
		dec.hram_sel = is_hram;
		dec.zero_rd  = !is_int || is_wr || unusable;
		dec.wdata    = (bus_address == DIV_ADDR) ? 8'h00 : write_data;

		unique case (bus_address)
			16'hFF03, 16'hFF08, 16'hFF09, 16'hFF0A,
			16'hFF0B, 16'hFF0C, 16'hFF0D, 16'hFF0E: dec.mask = MASK_FF;
			16'hFF11, 16'hFF16, 16'hFF1A:           dec.mask = MASK_C0;
			16'hFF14, 16'hFF19, 16'hFF1E, 16'hFF23: dec.mask = MASK_40;
			16'hFF1C:                               dec.mask = MASK_60;
			default:                                dec.mask = MASK_NONE;
		endcase
	end

endmodule

// ===== tb/sv/himm_access_checker.sv =====
`timescale 1ns / 1ps

module himm_access_checker import himm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] bus_address,
	input  logic        opcode,
	input  logic [7:0]  write_data,
	input  logic        done,
	input  logic [7:0]  read_data,
	input  logic [1:0]  region,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);

	localparam logic [15:0] WRAM_BASE   = 16'hC000;
	localparam logic [15:0] ECHO_BASE   = 16'hE000;
	localparam logic [15:0] SIO_UNUSED  = 16'hFF03;
	localparam logic [15:0] TIM_GAP_LO  = 16'hFF08;
	localparam logic [15:0] TIM_GAP_HI  = 16'hFF0E;
	localparam logic [15:0] NR11        = 16'hFF11;
	localparam logic [15:0] NR14        = 16'hFF14;
	localparam logic [15:0] NR21        = 16'hFF16;
	localparam logic [15:0] NR24        = 16'hFF19;
	localparam logic [15:0] NR30        = 16'hFF1A;
	localparam logic [15:0] NR32        = 16'hFF1C;
	localparam logic [15:0] NR34        = 16'hFF1E;
	localparam logic [15:0] NR44        = 16'hFF23;
	localparam int          MAX_REPORTS = 20;

	typedef struct packed {
		logic [7:0] rd;
		region_t    rgn;
	} bus_result_t;

	logic [7:0]  wram_copy [8192];
	logic [7:0]  hram_copy [512];
	bus_result_t expected_q [$];
	bus_result_t oldest;
	int          i;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	function automatic region_t decode_region(input logic [15:0] a);
		if (!a[15])
			return REGION_ROM;
		if (a[15:13] == 3'b100)
			return REGION_VRAM;
		if (a[15:13] == 3'b101)
			return REGION_ERAM;
		return REGION_INT;
	endfunction

	function automatic logic [7:0] visible_byte(input logic [15:0] a, input logic [7:0] b);
		if (a == SIO_UNUSED || (a >= TIM_GAP_LO && a <= TIM_GAP_HI))
			return 8'hFF;
		if (a == NR11 || a == NR21 || a == NR30)
			return b & 8'hC0;
		if (a == NR14 || a == NR24 || a == NR34 || a == NR44)
			return b & 8'h40;
		if (a == NR32)
			return b & 8'h60;
		return b;
	endfunction

	function automatic logic [7:0] internal_access(input logic [15:0] a, input logic wr,
			input logic [7:0] d);
		logic [15:0] wa;
		if (a >= HRAM_BASE) begin
			if (a >= UNUSED_LO && a <= UNUSED_HI)
				return 8'h00;
			if (wr) begin
				hram_copy[a[8:0]] = (a == DIV_ADDR) ? 8'h00 : d;
				return 8'h00;
			end
			return visible_byte(a, hram_copy[a[8:0]]);
		end
		// echo area folds back onto work RAM
		wa = (a >= ECHO_BASE) ? a - 16'h2000 : a;
		wa = wa - WRAM_BASE;
		if (wr) begin
			wram_copy[wa[12:0]] = d;
			return 8'h00;
		end
		return wram_copy[wa[12:0]];
	endfunction

	function automatic bus_result_t predict_access(input logic [15:0] a, input op_t op,
			input logic [7:0] d);
		bus_result_t r;
		r.rgn = decode_region(a);
		r.rd  = (r.rgn == REGION_INT) ? internal_access(a, op == OP_WRITE, d) : 8'h00;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < 8192; i++)
				wram_copy[i] = 8'h00;
			for (i = 0; i < 512; i++)
				hram_copy[i] = 8'h00;
			expected_q.delete();
			fail_count   = 0;
			results_seen = 0;
			pending     <= 0;
		end else begin
			if (done) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result rd=%02h region=%0d with no request outstanding",
						read_data, region));
				end else begin
					oldest = expected_q.pop_front();
					if (read_data !== oldest.rd)
						report_mismatch($sformatf("read_data %02h, expected %02h",
							read_data, oldest.rd));
					if (region !== oldest.rgn)
						report_mismatch($sformatf("region %0d, expected %0d",
							region, oldest.rgn));
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_access(bus_address, op_t'(opcode), write_data));
			pending <= expected_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_handheld_internal_memory_map.sv =====
`timescale 1ns / 1ps

module tb_handheld_internal_memory_map;
	import himm_pkg::*;

	localparam int RANDOM_REQUESTS = 650;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [15:0] bus_address = 16'h0000;
	logic        opcode      = OP_READ;
	logic [7:0]  write_data  = 8'h00;
	logic        busy;
	logic        done;
	logic [7:0]  read_data;
	logic [1:0]  region;

	int          fail_count;
	int          pending;
	int          results_seen;
	int          n_issued;
	int          n_writes;
	int          n_random;
	int          burst;
	int          gap;
	int          k;
	int          guard;
	logic [15:0] written_q [$];
	logic [15:0] pick;
	op_t         pick_op;

	handheld_internal_memory_map u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.bus_address (bus_address),
		.opcode      (opcode),
		.write_data  (write_data),
		.done        (done),
		.read_data   (read_data),
		.region      (region)
	);

	himm_access_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.bus_address  (bus_address),
		.opcode       (opcode),
		.write_data   (write_data),
		.done         (done),
		.read_data    (read_data),
		.region       (region),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	always #1 clk = ~clk;

	task automatic issue_request(input logic [15:0] a, input op_t op, input logic [7:0] d);
		start       <= 1'b1;
		bus_address <= a;
		opcode      <= op;
		write_data  <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		n_issued++;
		if (op == OP_WRITE)
			n_writes++;
	endtask

	function automatic logic [15:0] pick_address();
		logic [15:0] a;
		case ($urandom_range(0, 11))
			0: a = 16'($urandom_range(0, 16'hFFFF));
			1: a = 16'($urandom_range(0, 16'hBFFF));
			2: a = 16'(16'hC000 + $urandom_range(0, 16'h1FFF));
			3: a = 16'(16'hE000 + $urandom_range(0, 16'h1DFF));
			4, 5, 6: begin
				// revisit a written address, sometimes through its echo alias
				if (written_q.size() == 0) begin
					a = 16'(16'hC000 + $urandom_range(0, 15));
				end else begin
					a = written_q[$urandom_range(0, written_q.size() - 1)];
					if ($urandom_range(0, 1)) begin
						if (a >= 16'hC000 && a < 16'hDE00)
							a = a + 16'h2000;
						else if (a >= 16'hE000 && a < 16'hFE00)
							a = a - 16'h2000;
					end
				end
			end
			7: a = 16'(16'hC000 + $urandom_range(0, 15));
			8: a = 16'(16'hFE00 + $urandom_range(0, 511));
			9: a = 16'(16'hFF00 + $urandom_range(0, 16'h2F));
			10: a = 16'(16'hFEA0 + $urandom_range(0, 16'h5F));
			default: a = 16'(16'hFF80 + $urandom_range(0, 127));
		endcase
		return a;
	endfunction

	initial begin
		#200000;
		$display("FAIL handheld_internal_memory_map");
		$finish;
	end

	initial begin
		n_issued = 0;
		n_writes = 0;
		n_random = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// busy covers the clearing sweep; the first request waits it out
		issue_request(16'hC000, OP_WRITE, 8'hA5);
		issue_request(16'hE000, OP_READ,  8'h00);
		issue_request(16'hFDFF, OP_WRITE, 8'h5A);
		issue_request(16'hDDFF, OP_READ,  8'hFF);
		issue_request(16'hFE9F, OP_WRITE, 8'h3C);
		issue_request(16'hFE9F, OP_READ,  8'h00);
		issue_request(16'hFEA0, OP_WRITE, 8'h77);
		issue_request(16'hFEA0, OP_READ,  8'h00);
		issue_request(16'hFEFF, OP_READ,  8'h00);
		issue_request(16'hFF04, OP_WRITE, 8'hAB);
		issue_request(16'hFF04, OP_READ,  8'h00);
		issue_request(16'hFF03, OP_WRITE, 8'h12);
		issue_request(16'hFF03, OP_READ,  8'h00);
		issue_request(16'hFF11, OP_WRITE, 8'hFF);
		issue_request(16'hFF11, OP_READ,  8'h00);
		issue_request(16'hFF14, OP_WRITE, 8'hFF);
		issue_request(16'hFF14, OP_READ,  8'h00);
		issue_request(16'hFF1C, OP_WRITE, 8'hFF);
		issue_request(16'hFF1C, OP_READ,  8'h00);
		issue_request(16'hFFFF, OP_WRITE, 8'h81);
		issue_request(16'hFFFF, OP_READ,  8'h00);
		issue_request(16'h0000, OP_READ,  8'h00);
		issue_request(16'h7FFF, OP_WRITE, 8'hFF);
		issue_request(16'h8000, OP_READ,  8'h00);
		issue_request(16'hBFFF, OP_WRITE, 8'h00);

		while (n_random < RANDOM_REQUESTS) begin
			burst = $urandom_range(0, 3) ? $urandom_range(1, 12) : $urandom_range(20, 60);
			for (k = 0; k < burst && n_random < RANDOM_REQUESTS; k++) begin
				pick    = pick_address();
				pick_op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_READ;
				issue_request(pick, pick_op, 8'($urandom_range(0, 255)));
				n_random++;
				if (pick_op == OP_WRITE && pick >= 16'hC000) begin
					written_q.push_back(pick);
					if (written_q.size() > 16)
						void'(written_q.pop_front());
				end
			end
			gap = $urandom_range(0, 3) ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;

		for (guard = 0; guard < 64 && pending != 0; guard++)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Run covered %0d requests (%0d writes) over ROM, video RAM, external RAM,",
			n_issued, n_writes);
		$display("work RAM with its echo, high memory and masked registers; %0d results checked",
			results_seen);
		if (fail_count == 0 && pending == 0)
			$display("PASS handheld_internal_memory_map");
		else
			$display("FAIL handheld_internal_memory_map");
		$finish;
	end

endmodule
